// ----- rtl/bus_frame_command_decoder_macros.svh -----
// Assertion macros for the bus frame command decoder checker.
// Each macro expects clk and rst in the scope where it is used.
`ifndef BUS_FRAME_COMMAND_DECODER_MACROS_SVH
`define BUS_FRAME_COMMAND_DECODER_MACROS_SVH

// same-cycle implication, off during reset
`define BFCD_ASSERT_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, off during reset
`define BFCD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

// condition that must hold in the cycle after reset is seen
`define BFCD_ASSERT_RESET(label, post, msg) \
  label: assert property (@(posedge clk) rst |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/bfcd_pkg.sv -----
// Shared types and constants of the bus frame command decoder.
// No dependencies; the decoder modules and the checker import this package.
package bfcd_pkg;

  localparam int CAPTURE_DEPTH = 6;
  localparam int CAPT_IDX_W    = $clog2(CAPTURE_DEPTH);
  localparam int COUNT_W       = 9;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] MIN_BYTES = COUNT_W'(4);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST_HIGH = 2'd2;

  localparam logic [7:0] OWN_ADDRESS_RESET    = 8'd24;
  localparam logic [7:0] BROADCAST_LOW_RESET  = 8'd0;
  localparam logic [7:0] BROADCAST_HIGH_RESET = 8'd255;

  localparam logic [7:0] LEN_POLL = 8'd3;
  localparam logic [7:0] LEN_CD   = 8'd5;
  localparam logic [7:0] OP_POLL  = 8'h01;
  localparam logic [7:0] OP_CD    = 8'h38;

  localparam logic [7:0] SUB_STATUS   = 8'h00;
  localparam logic [7:0] SUB_STOP     = 8'h01;
  localparam logic [7:0] SUB_PAUSE    = 8'h02;
  localparam logic [7:0] SUB_PLAY     = 8'h03;
  localparam logic [7:0] SUB_FAST     = 8'h04;
  localparam logic [7:0] SUB_SEEK     = 8'h05;
  localparam logic [7:0] SUB_DISC     = 8'h06;
  localparam logic [7:0] SUB_SCAN     = 8'h07;
  localparam logic [7:0] SUB_RANDOM   = 8'h08;
  localparam logic [7:0] SUB_ALT_SEEK = 8'h0a;

  localparam logic [7:0] DISC_MIN = 8'd1;
  localparam logic [7:0] DISC_MAX = 8'd6;

  typedef enum logic [4:0] {
    CMD_TRAFFIC       = 5'd0,
    CMD_POLL          = 5'd1,
    CMD_STATUS        = 5'd2,
    CMD_STOP          = 5'd3,
    CMD_PAUSE         = 5'd4,
    CMD_PLAY          = 5'd5,
    CMD_FAST_REV      = 5'd6,
    CMD_FAST_FWD      = 5'd7,
    CMD_SEEK_NEXT     = 5'd8,
    CMD_SEEK_PREV     = 5'd9,
    CMD_ALT_SEEK_NEXT = 5'd10,
    CMD_ALT_SEEK_PREV = 5'd11,
    CMD_DISC_CHANGE   = 5'd12,
    CMD_SCAN_OFF      = 5'd13,
    CMD_SCAN_ON       = 5'd14,
    CMD_RANDOM_OFF    = 5'd15,
    CMD_RANDOM_ON     = 5'd16
  } cmd_t;

  typedef struct packed {
    logic       bad;
    logic [7:0] src;
    logic [7:0] len;
    logic [7:0] dst;
    logic [7:0] p0;
    logic [7:0] p1;
    logic [7:0] p2;
  } frame_t;

  typedef struct packed {
    logic [7:0] own_address;
    logic [7:0] broadcast_low;
    logic [7:0] broadcast_high;
  } cfg_t;

  typedef struct packed {
    logic       accepted;
    cmd_t       command;
    logic [2:0] disc;
  } result_t;

endpackage

// ----- rtl/bfcd_if.sv -----
// Valid/ready channel interfaces for message bytes and decoded results.
// Widths follow the fixed fields of the decoder.
interface bfcd_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       rx_error;

  modport source(output valid, data_byte, last_byte, rx_error, input ready);
  modport sink(input valid, data_byte, last_byte, rx_error, output ready);
endinterface

interface bfcd_result_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [4:0] command;
  logic [2:0] disc;

  modport source(output valid, accepted, command, disc, input ready);
  modport sink(input valid, accepted, command, disc, output ready);
endinterface

// ----- rtl/bfcd_accum.sv -----
// Per-byte accumulation: running XOR, saturating count, capture of the header bytes.
// Hands a completed frame summary to the decode stage; uses bfcd_pkg.
module bfcd_accum (
  input  logic            clk,
  input  logic            rst,
  input  logic            word_take,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  input  logic            rx_error,
  input  logic            frame_take,
  output logic            frame_valid,
  output bfcd_pkg::frame_t frame
);
  import bfcd_pkg::*;

  logic [7:0]         capt [CAPTURE_DEPTH];
  logic [7:0]         capt_next [CAPTURE_DEPTH];
  logic [7:0]         xor_acc;
  logic [7:0]         xor_next;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               err_seen;
  logic               err_next;
  frame_t             frame_next;

  always_comb begin
    capt_next = capt;
    if (count < COUNT_W'(CAPTURE_DEPTH)) begin
      capt_next[count[CAPT_IDX_W-1:0]] = data_byte;
    end
    xor_next   = xor_acc ^ data_byte;
    count_next = (count == COUNT_MAX) ? count : count + 1'b1;
    err_next   = err_seen | rx_error;

    frame_next.bad = err_next || (count_next < MIN_BYTES) || (xor_next != 8'd0);
    frame_next.src = capt_next[0];
    frame_next.len = capt_next[1];
    frame_next.dst = capt_next[2];
    frame_next.p0  = capt_next[3];
    frame_next.p1  = capt_next[4];
    frame_next.p2  = capt_next[5];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CAPTURE_DEPTH; i++) begin
        capt[i] <= 8'd0;
      end
      xor_acc     <= 8'd0;
      count       <= '0;
      err_seen    <= 1'b0;
      frame_valid <= 1'b0;
    end else begin
      frame_valid <= (word_take && last_byte) || (frame_valid && !frame_take);
      if (word_take) begin
        if (last_byte) begin
          for (int i = 0; i < CAPTURE_DEPTH; i++) begin
            capt[i] <= 8'd0;
          end
          xor_acc  <= 8'd0;
          count    <= '0;
          err_seen <= 1'b0;
        end else begin
          capt     <= capt_next;
          xor_acc  <= xor_next;
          count    <= count_next;
          err_seen <= err_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (word_take && last_byte) begin
      frame <= frame_next;
    end
  end

endmodule

// ----- rtl/bfcd_decode.sv -----
// Frame decode: filtering, addressing and command mapping into the result register.
// Uses bfcd_pkg for frame, configuration and result types.
module bfcd_decode (
  input  logic              clk,
  input  logic              rst,
  input  bfcd_pkg::frame_t  frame,
  input  logic              frame_valid,
  input  bfcd_pkg::cfg_t    cfg,
  input  logic              result_ready,
  output logic              frame_take,
  output logic              result_valid,
  output bfcd_pkg::result_t result
);
  import bfcd_pkg::*;

  result_t res_next;
  logic    addressed;
  logic    pair_ok;

  assign frame_take = frame_valid && (!result_valid || result_ready);

  always_comb begin
    res_next  = '{accepted: 1'b0, command: CMD_TRAFFIC, disc: 3'd0};
    addressed = (frame.dst == cfg.own_address) || (frame.dst == cfg.broadcast_low) ||
                (frame.dst == cfg.broadcast_high);
    pair_ok   = (frame.p2[7:1] == 7'd0);
    if (!frame.bad && (frame.src != cfg.own_address)) begin
      if (!addressed) begin
        res_next.accepted = 1'b1;
      end else if (frame.len == LEN_POLL && frame.p0 == OP_POLL) begin
        res_next.accepted = 1'b1;
        res_next.command  = CMD_POLL;
      end else if (frame.len == LEN_CD && frame.p0 == OP_CD) begin
        case (frame.p1)
          SUB_STATUS: begin
            res_next.accepted = 1'b1;
            res_next.command  = CMD_STATUS;
          end
          SUB_STOP: begin
            res_next.accepted = 1'b1;
            res_next.command  = CMD_STOP;
          end
          SUB_PAUSE: begin
            res_next.accepted = 1'b1;
            res_next.command  = CMD_PAUSE;
          end
          SUB_PLAY: begin
            res_next.accepted = 1'b1;
            res_next.command  = CMD_PLAY;
          end
          SUB_FAST: begin
            res_next.accepted = pair_ok;
            if (pair_ok) begin
              res_next.command = frame.p2[0] ? CMD_FAST_FWD : CMD_FAST_REV;
            end
          end
          SUB_SEEK: begin
            res_next.accepted = pair_ok;
            if (pair_ok) begin
              res_next.command = frame.p2[0] ? CMD_SEEK_PREV : CMD_SEEK_NEXT;
            end
          end
          SUB_ALT_SEEK: begin
            res_next.accepted = pair_ok;
            if (pair_ok) begin
              res_next.command = frame.p2[0] ? CMD_ALT_SEEK_PREV : CMD_ALT_SEEK_NEXT;
            end
          end
          SUB_SCAN: begin
            res_next.accepted = pair_ok;
            if (pair_ok) begin
              res_next.command = frame.p2[0] ? CMD_SCAN_ON : CMD_SCAN_OFF;
            end
          end
          SUB_RANDOM: begin
            res_next.accepted = pair_ok;
            if (pair_ok) begin
              res_next.command = frame.p2[0] ? CMD_RANDOM_ON : CMD_RANDOM_OFF;
            end
          end
          SUB_DISC: begin
            if (frame.p2 inside {[DISC_MIN:DISC_MAX]}) begin
              res_next.accepted = 1'b1;
              res_next.command  = CMD_DISC_CHANGE;
              res_next.disc     = frame.p2[2:0];
            end
          end
          default: begin
            res_next.accepted = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (frame_take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_take) begin
      result <= res_next;
    end
  end

endmodule

// ----- rtl/bus_frame_command_decoder.sv -----
// Top level of the bus frame command decoder; instantiates bfcd_accum and bfcd_decode.
// Depends on bfcd_pkg and the channel interfaces in bfcd_if.sv.
//
// Takes one message byte per clock on the frame channel, with no gaps between
// messages, as long as ready is high. Each byte is registered in the accumulate
// registers (XOR, count, header capture); the last byte of a message yields one
// result through a frame register and then the decode/result register.
// A waiting result does not stop the byte stream until both internal stages hold
// a finished message. Configuration writes take effect at once and belong to idle
// periods; there is no start-up sweep, so the block takes bytes right after reset.
module bus_frame_command_decoder (
  input  logic                             clk,
  input  logic                             rst,
  bfcd_frame_if.sink                       frame,
  bfcd_result_if.source                    result,
  input  logic                             cfg_we,
  input  logic [bfcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                       cfg_data
);
  import bfcd_pkg::*;

  cfg_t    cfg;
  frame_t  frame_reg;
  logic    frame_valid;
  logic    frame_take;
  logic    word_take;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_address    <= OWN_ADDRESS_RESET;
      cfg.broadcast_low  <= BROADCAST_LOW_RESET;
      cfg.broadcast_high <= BROADCAST_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_ADDRESS:    cfg.own_address    <= cfg_data;
        CFG_BROADCAST_LOW:  cfg.broadcast_low  <= cfg_data;
        CFG_BROADCAST_HIGH: cfg.broadcast_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign frame.ready = !frame_valid || frame_take;
  assign word_take   = frame.valid && frame.ready;

  bfcd_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .word_take   (word_take),
    .data_byte   (frame.data_byte),
    .last_byte   (frame.last_byte),
    .rx_error    (frame.rx_error),
    .frame_take  (frame_take),
    .frame_valid (frame_valid),
    .frame       (frame_reg)
  );

  bfcd_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .frame        (frame_reg),
    .frame_valid  (frame_valid),
    .cfg          (cfg),
    .result_ready (result.ready),
    .frame_take   (frame_take),
    .result_valid (result.valid),
    .result       (res)
  );

  assign result.accepted = res.accepted;
  assign result.command  = res.command;
  assign result.disc     = res.disc;

endmodule

// ----- rtl/bfcd_checker.sv -----
// Port-level checks of the bus frame command decoder, bound to the top level.
// Uses bfcd_pkg and the macros in bus_frame_command_decoder_macros.svh.
`include "bus_frame_command_decoder_macros.svh"

module bfcd_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_ready,
  input logic       accepted,
  input logic [4:0] command,
  input logic [2:0] disc
);
  import bfcd_pkg::*;

  `BFCD_ASSERT_RESET(a_reset_clears, !result_valid, "result valid right after reset")
  `BFCD_ASSERT_NEXT(a_hold_stalled, result_valid && !result_ready, result_valid && $stable(accepted) && $stable(command) && $stable(disc), "stalled result word changed")
  `BFCD_ASSERT_IMPLY(a_reject_zero, result_valid && !accepted, command == CMD_TRAFFIC && disc == 3'd0, "rejected word carries a command")
  `BFCD_ASSERT_IMPLY(a_disc_pair, result_valid, (disc != 3'd0) == (command == CMD_DISC_CHANGE), "disc number without disc change")

endmodule

bind bus_frame_command_decoder bfcd_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .accepted     (result.accepted),
  .command      (result.command),
  .disc         (result.disc)
);
